>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the bus frame parser.
// Defining NO_ASSERTIONS removes every check; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BFP_ASSERT(lbl, prop, msg)
`define BFP_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/bfp_pkg.sv
// Types and constants of the bus frame parser.
// No dependencies; used by bfp_core, bfp_skid and bus_frame_parser.
`timescale 1ns / 1ps

package bfp_pkg;

    localparam logic [7:0] CODE_SOH = 8'h01;
    localparam logic [7:0] CODE_STX = 8'h02;
    localparam logic [7:0] CODE_ETX = 8'h03;
    localparam logic [7:0] CODE_ENQ = 8'h05;
    localparam logic [7:0] CODE_ACK = 8'h06;
    localparam logic [7:0] CODE_NAK = 8'h15;
    localparam logic [7:0] CODE_RS  = 8'h1E;

    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd16;

    localparam int unsigned TDATA_W = 80;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_DST_H = 4'd1,
        PH_DST_L = 4'd2,
        PH_RS    = 4'd3,
        PH_SRC_H = 4'd4,
        PH_SRC_L = 4'd5,
        PH_STX   = 4'd6,
        PH_DIR   = 4'd7,
        PH_CMD   = 4'd8,
        PH_LEN   = 4'd9,
        PH_PAY_H = 4'd10,
        PH_PAY_L = 4'd11,
        PH_ETX   = 4'd12
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_RS    = 3'd1,
        ST_NO_STX   = 3'd2,
        ST_BAD_DIR  = 3'd3,
        ST_LEN_HIGH = 3'd4,
        ST_NO_ETX   = 3'd5
    } status_t;

    typedef struct packed {
        logic        has_payload;
        logic [15:0] payload;
        logic [7:0]  length;
        logic [7:0]  command;
        logic [7:0]  dir_byte;
        logic [15:0] src_addr;
        logic [15:0] dest_addr;
        status_t     status;
    } result_t;

endpackage

>>> rtl/bus_frame_parser.sv
// Top level of the bus frame parser: byte stream in, frame results out.
// Depends on bfp_pkg, bfp_core, bfp_skid and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
//   s_axis carries received bytes, one per request. m_axis carries one
//   result per finished or failed frame; bytes while hunting and bytes in
//   the middle of a frame give no result.
//   cfg_we/cfg_wdata write the payload limit (reset value 16); write it only
//   while no frame is in flight.
// Timing:
//   One byte is accepted per clock while s_axis_tready is high. The byte that
//   ends a frame is parsed in a single pass from the state registers into the
//   output register, or into the skid entry while m_axis stalls.
// Reset:
//   rst_n returns the parser to hunting for ENQ, clears the frame fields,
//   restores the payload limit and empties the output stage.
// Stall:
//   While m_axis_tready is low the result holds and one more result fits
//   in the skid entry; s_axis_tready drops only once that entry is full.

module bus_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // status, dest_addr, src_addr, dir_byte,
                                        // command, length, payload, zero pad
    output logic        m_axis_tuser,   // has_payload
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata       // max_payload
);

    logic [7:0]       max_payload_reg;
    logic             byte_accept;
    logic             res_valid;
    bfp_pkg::result_t res_data;
    bfp_pkg::result_t out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= bfp_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            max_payload_reg <= cfg_wdata;
        end
    end

    assign byte_accept = s_axis_tvalid && s_axis_tready;

    bfp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .rx_byte     (s_axis_tdata),
        .max_payload (max_payload_reg),
        .res_valid   (res_valid),
        .result      (res_data)
    );

    bfp_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (s_axis_tready),
        .in_data   (res_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = {5'b00000, out_data.payload, out_data.length, out_data.command,
                           out_data.dir_byte, out_data.src_addr, out_data.dest_addr,
                           out_data.status};
    assign m_axis_tuser = out_data.has_payload;

    `BFP_ASSERT(a_ready_low_means_full, !s_axis_tready |-> m_axis_tvalid, "input blocked with empty output")
    `BFP_ASSERT(a_stall_fills_skid, m_axis_tvalid && !m_axis_tready && res_valid |=> !s_axis_tready, "stalled result not held in skid")
    `BFP_ASSERT_NEVER(a_payload_only_ok, m_axis_tvalid && m_axis_tuser && (m_axis_tdata[2:0] != bfp_pkg::ST_OK), "payload flag on error result")

endmodule

>>> rtl/bfp_core.sv
// Frame parsing state machine: one received byte per accepted request.
// Depends on bfp_pkg.
`timescale 1ns / 1ps

module bfp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_accept,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        max_payload,
    output logic              res_valid,
    output bfp_pkg::result_t  result
);

    bfp_pkg::phase_t  phase_reg, phase_next;
    logic [15:0]      dest_reg, dest_next;
    logic [15:0]      src_reg, src_next;
    logic [7:0]       dir_reg, dir_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       len_reg, len_next;
    logic [15:0]      payload_reg, payload_next;
    logic             emit;
    logic             with_payload;
    bfp_pkg::status_t status;
    logic             len_too_high;

    assign len_too_high = ({1'b0, rx_byte} + 9'd1) > {1'b0, max_payload};

    always_comb
    begin
        phase_next   = phase_reg;
        dest_next    = dest_reg;
        src_next     = src_reg;
        dir_next     = dir_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        payload_next = payload_reg;
        emit         = 1'b0;
        with_payload = 1'b0;
        status       = bfp_pkg::ST_OK;
        unique case (phase_reg)
            bfp_pkg::PH_DST_H:
            begin
                dest_next  = {rx_byte, 8'h00};
                phase_next = bfp_pkg::PH_DST_L;
            end
            bfp_pkg::PH_DST_L:
            begin
                dest_next  = {dest_reg[15:8], rx_byte};
                phase_next = bfp_pkg::PH_RS;
            end
            bfp_pkg::PH_RS:
            begin
                if (rx_byte != bfp_pkg::CODE_RS)
                begin
                    emit   = 1'b1;
                    status = bfp_pkg::ST_NO_RS;
                end
                else
                begin
                    phase_next = bfp_pkg::PH_SRC_H;
                end
            end
            bfp_pkg::PH_SRC_H:
            begin
                src_next   = {rx_byte, 8'h00};
                phase_next = bfp_pkg::PH_SRC_L;
            end
            bfp_pkg::PH_SRC_L:
            begin
                src_next   = {src_reg[15:8], rx_byte};
                phase_next = bfp_pkg::PH_STX;
            end
            bfp_pkg::PH_STX:
            begin
                if (rx_byte != bfp_pkg::CODE_STX)
                begin
                    emit   = 1'b1;
                    status = bfp_pkg::ST_NO_STX;
                end
                else
                begin
                    phase_next = bfp_pkg::PH_DIR;
                end
            end
            bfp_pkg::PH_DIR:
            begin
                dir_next = rx_byte;
                if (rx_byte == bfp_pkg::CODE_SOH || rx_byte == bfp_pkg::CODE_ACK
                    || rx_byte == bfp_pkg::CODE_NAK)
                begin
                    phase_next = bfp_pkg::PH_CMD;
                end
                else
                begin
                    emit   = 1'b1;
                    status = bfp_pkg::ST_BAD_DIR;
                end
            end
            bfp_pkg::PH_CMD:
            begin
                cmd_next   = rx_byte;
                phase_next = (dir_reg == bfp_pkg::CODE_NAK) ? bfp_pkg::PH_ETX
                                                            : bfp_pkg::PH_LEN;
            end
            bfp_pkg::PH_LEN:
            begin
                len_next = rx_byte;
                if (len_too_high)
                begin
                    emit   = 1'b1;
                    status = bfp_pkg::ST_LEN_HIGH;
                end
                else
                begin
                    phase_next = (rx_byte != 8'h00) ? bfp_pkg::PH_PAY_H
                                                    : bfp_pkg::PH_ETX;
                end
            end
            bfp_pkg::PH_PAY_H:
            begin
                payload_next = {rx_byte, 8'h00};
                phase_next   = bfp_pkg::PH_PAY_L;
            end
            bfp_pkg::PH_PAY_L:
            begin
                payload_next = {payload_reg[15:8], rx_byte};
                phase_next   = bfp_pkg::PH_ETX;
            end
            bfp_pkg::PH_ETX:
            begin
                emit = 1'b1;
                if (rx_byte != bfp_pkg::CODE_ETX)
                begin
                    status = bfp_pkg::ST_NO_ETX;
                end
                else
                begin
                    with_payload = (dir_reg != bfp_pkg::CODE_NAK) && (len_reg != 8'h00);
                end
            end
            default:
            begin
                if (rx_byte == bfp_pkg::CODE_ENQ)
                begin
                    dest_next    = '0;
                    src_next     = '0;
                    dir_next     = '0;
                    cmd_next     = '0;
                    len_next     = '0;
                    payload_next = '0;
                    phase_next   = bfp_pkg::PH_DST_H;
                end
                else
                begin
                    phase_next = bfp_pkg::PH_HUNT;
                end
            end
        endcase
        if (emit)
        begin
            phase_next = bfp_pkg::PH_HUNT;
        end
    end

    always_comb
    begin
        result.status      = status;
        result.dest_addr   = dest_next;
        result.src_addr    = src_next;
        result.dir_byte    = dir_next;
        result.command     = cmd_next;
        result.length      = len_next;
        result.payload     = with_payload ? payload_next : 16'h0000;
        result.has_payload = with_payload;
    end

    assign res_valid = byte_accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= bfp_pkg::PH_HUNT;
            dest_reg    <= '0;
            src_reg     <= '0;
            dir_reg     <= '0;
            cmd_reg     <= '0;
            len_reg     <= '0;
            payload_reg <= '0;
        end
        else if (byte_accept)
        begin
            phase_reg   <= phase_next;
            dest_reg    <= dest_next;
            src_reg     <= src_next;
            dir_reg     <= dir_next;
            cmd_reg     <= cmd_next;
            len_reg     <= len_next;
            payload_reg <= payload_next;
        end
    end

endmodule

>>> rtl/bfp_skid.sv
// Registered output stage with one skid entry for frame results.
// Depends on bfp_pkg.
`timescale 1ns / 1ps

module bfp_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bfp_pkg::result_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bfp_pkg::result_t  out_data
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    bfp_pkg::result_t out_data_reg, out_data_next;
    bfp_pkg::result_t skid_data_reg, skid_data_next;
    logic             in_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            out_valid_next  = skid_valid_reg || in_fire;
            out_data_next   = skid_valid_reg ? skid_data_reg : in_data;
            skid_valid_next = 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for bus_frame_parser: byte requests in, frame results out.
// Depends on bfp_pkg and the bus_frame_parser RTL; a scoreboard class predicts each result.
`timescale 1ns / 1ps

module tb_top;

    class frame_scoreboard;
        bfp_pkg::phase_t    phase;
        logic [7:0]         limit;
        logic [15:0]        dest_q;
        logic [15:0]        src_q;
        logic [15:0]        pay_q;
        logic [7:0]         dir_q;
        logic [7:0]         cmd_q;
        logic [7:0]         len_q;
        bfp_pkg::result_t   expected_frames[$];
        int                 mismatches;
        int                 bytes_seen;
        int                 results_seen;
        int                 status_hits[6];

        function new();
            phase = bfp_pkg::PH_HUNT;
            limit = bfp_pkg::MAX_PAYLOAD_RESET;
            clear_fields();
            mismatches = 0;
            bytes_seen = 0;
            results_seen = 0;
            foreach (status_hits[i])
                status_hits[i] = 0;
        endfunction

        function void clear_fields();
            dest_q = '0;
            src_q  = '0;
            pay_q  = '0;
            dir_q  = '0;
            cmd_q  = '0;
            len_q  = '0;
        endfunction

        function void set_limit(logic [7:0] value);
            limit = value;
        endfunction

        function void close_frame(bfp_pkg::status_t st, logic with_pay);
            bfp_pkg::result_t r;
            r.status      = st;
            r.dest_addr   = dest_q;
            r.src_addr    = src_q;
            r.dir_byte    = dir_q;
            r.command     = cmd_q;
            r.length      = len_q;
            r.payload     = with_pay ? pay_q : 16'h0000;
            r.has_payload = with_pay;
            expected_frames.push_back(r);
            phase = bfp_pkg::PH_HUNT;
        endfunction

        // Advance the frame parse by one accepted byte.
        function void parse_byte(logic [7:0] b);
            bytes_seen++;
            case (phase)
                bfp_pkg::PH_DST_H:
                begin
                    dest_q = {b, 8'h00};
                    phase  = bfp_pkg::PH_DST_L;
                end
                bfp_pkg::PH_DST_L:
                begin
                    dest_q[7:0] = b;
                    phase       = bfp_pkg::PH_RS;
                end
                bfp_pkg::PH_RS:
                begin
                    if (b != bfp_pkg::CODE_RS)
                        close_frame(bfp_pkg::ST_NO_RS, 1'b0);
                    else
                        phase = bfp_pkg::PH_SRC_H;
                end
                bfp_pkg::PH_SRC_H:
                begin
                    src_q = {b, 8'h00};
                    phase = bfp_pkg::PH_SRC_L;
                end
                bfp_pkg::PH_SRC_L:
                begin
                    src_q[7:0] = b;
                    phase      = bfp_pkg::PH_STX;
                end
                bfp_pkg::PH_STX:
                begin
                    if (b != bfp_pkg::CODE_STX)
                        close_frame(bfp_pkg::ST_NO_STX, 1'b0);
                    else
                        phase = bfp_pkg::PH_DIR;
                end
                bfp_pkg::PH_DIR:
                begin
                    dir_q = b;
                    if (b == bfp_pkg::CODE_SOH || b == bfp_pkg::CODE_ACK
                        || b == bfp_pkg::CODE_NAK)
                        phase = bfp_pkg::PH_CMD;
                    else
                        close_frame(bfp_pkg::ST_BAD_DIR, 1'b0);
                end
                bfp_pkg::PH_CMD:
                begin
                    cmd_q = b;
                    phase = (dir_q == bfp_pkg::CODE_NAK) ? bfp_pkg::PH_ETX
                                                         : bfp_pkg::PH_LEN;
                end
                bfp_pkg::PH_LEN:
                begin
                    len_q = b;
                    if ({1'b0, b} + 9'd1 > {1'b0, limit})
                        close_frame(bfp_pkg::ST_LEN_HIGH, 1'b0);
                    else
                        phase = (b != 8'h00) ? bfp_pkg::PH_PAY_H : bfp_pkg::PH_ETX;
                end
                bfp_pkg::PH_PAY_H:
                begin
                    pay_q = {b, 8'h00};
                    phase = bfp_pkg::PH_PAY_L;
                end
                bfp_pkg::PH_PAY_L:
                begin
                    pay_q[7:0] = b;
                    phase      = bfp_pkg::PH_ETX;
                end
                bfp_pkg::PH_ETX:
                begin
                    if (b != bfp_pkg::CODE_ETX)
                        close_frame(bfp_pkg::ST_NO_ETX, 1'b0);
                    else
                        close_frame(bfp_pkg::ST_OK,
                                    dir_q != bfp_pkg::CODE_NAK && len_q != 8'h00);
                end
                default:
                begin
                    if (b == bfp_pkg::CODE_ENQ)
                    begin
                        clear_fields();
                        phase = bfp_pkg::PH_DST_H;
                    end
                    else
                    begin
                        phase = bfp_pkg::PH_HUNT;
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(bfp_pkg::result_t got);
            bfp_pkg::result_t want;
            if (expected_frames.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing pending, expected none, actual status %0d",
                         $time, got.status);
                return;
            end
            want = expected_frames.pop_front();
            results_seen++;
            status_hits[want.status]++;
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("dest_addr", want.dest_addr, got.dest_addr);
            compare_field("src_addr", want.src_addr, got.src_addr);
            compare_field("dir_byte", 16'(want.dir_byte), 16'(got.dir_byte));
            compare_field("command", 16'(want.command), 16'(got.command));
            compare_field("length", 16'(want.length), 16'(got.length));
            compare_field("payload", want.payload, got.payload);
            compare_field("has_payload", 16'(want.has_payload), 16'(got.has_payload));
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;           // status, dest_addr, src_addr, dir_byte,
                                         // command, length, payload, zero pad
    logic        m_axis_tuser;           // has_payload
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;      // max_payload

    frame_scoreboard sb = new();
    bit              no_idle = 1'b0;
    int              hold_cycles = 0;
    int              limits_used = 1;

    bus_frame_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 5));
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.parse_byte(b);
    endtask

    task automatic send_frame(input logic [15:0] dest, input logic [15:0] src,
                              input logic [7:0] sep1, input logic [7:0] sep2,
                              input logic [7:0] dir, input logic [7:0] cmd,
                              input logic [7:0] len, input logic [15:0] pay,
                              input logic [7:0] stop);
        send_byte(bfp_pkg::CODE_ENQ);
        send_byte(dest[15:8]);
        send_byte(dest[7:0]);
        send_byte(sep1);
        send_byte(src[15:8]);
        send_byte(src[7:0]);
        send_byte(sep2);
        send_byte(dir);
        send_byte(cmd);
        if (dir != bfp_pkg::CODE_NAK)
        begin
            send_byte(len);
            if (len != 8'h00)
            begin
                send_byte(pay[15:8]);
                send_byte(pay[7:0]);
            end
        end
        send_byte(stop);
    endtask

    // Close any open frame, hold the sender and wait for every pending result.
    task automatic settle();
        while (sb.phase != bfp_pkg::PH_HUNT)
            send_byte(8'h00);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_frames.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_limit(value);
        limits_used++;
    endtask

    task automatic random_frame();
        int          kind;
        int          lim;
        logic [7:0]  sep1;
        logic [7:0]  sep2;
        logic [7:0]  dir;
        logic [7:0]  len;
        logic [7:0]  stop;
        logic [7:0]  dirs[3];
        dirs = '{bfp_pkg::CODE_SOH, bfp_pkg::CODE_ACK, bfp_pkg::CODE_NAK};
        kind = int'($urandom_range(0, 9));
        lim  = int'(sb.limit);
        sep1 = bfp_pkg::CODE_RS;
        sep2 = bfp_pkg::CODE_STX;
        dir  = dirs[$urandom_range(0, 2)];
        stop = bfp_pkg::CODE_ETX;
        if (lim > 0 && $urandom_range(0, 2) != 0)
            len = 8'($urandom_range(0, lim - 1));
        else
            len = 8'($urandom_range(0, 255));
        case (kind)
            6: do sep1 = 8'($urandom); while (sep1 == bfp_pkg::CODE_RS);
            7: do sep2 = 8'($urandom); while (sep2 == bfp_pkg::CODE_STX);
            8: do dir = 8'($urandom);
               while (dir == bfp_pkg::CODE_SOH || dir == bfp_pkg::CODE_ACK
                      || dir == bfp_pkg::CODE_NAK);
            9: do stop = 8'($urandom); while (stop == bfp_pkg::CODE_ETX);
            default: ;
        endcase
        send_frame(16'($urandom), 16'($urandom), sep1, sep2, dir, 8'($urandom), len,
                   16'($urandom), stop);
    endtask

    task automatic random_traffic(input int n_bytes);
        int target;
        target = sb.bytes_seen + n_bytes;
        while (sb.bytes_seen < target)
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            random_frame();
        end
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_cycles > 0)
            begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                gap = no_idle ? 0 : int'($urandom_range(0, 5));
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sb.check_result(bfp_pkg::result_t'({m_axis_tuser, m_axis_tdata[74:0]}));
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limit of 16: noise, good frames, each error kind.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(bfp_pkg::CODE_RS);
        send_byte(bfp_pkg::CODE_ETX);
        send_frame(16'h0000, 16'hFFFF, bfp_pkg::CODE_RS, bfp_pkg::CODE_STX,
                   bfp_pkg::CODE_SOH, 8'h00, 8'd15, 16'hFFFF, bfp_pkg::CODE_ETX);
        send_frame(16'hFFFF, 16'h0000, bfp_pkg::CODE_RS, bfp_pkg::CODE_STX,
                   bfp_pkg::CODE_ACK, 8'hFF, 8'd0, 16'h0000, bfp_pkg::CODE_ETX);
        send_frame(16'hA55A, 16'h5AA5, bfp_pkg::CODE_RS, bfp_pkg::CODE_STX,
                   bfp_pkg::CODE_NAK, 8'h3C, 8'd0, 16'h0000, bfp_pkg::CODE_ETX);
        send_frame(16'h1234, 16'h5678, bfp_pkg::CODE_RS, bfp_pkg::CODE_STX,
                   bfp_pkg::CODE_SOH, 8'h81, 8'd16, 16'h0000, bfp_pkg::CODE_ETX);
        send_frame(16'h0F0F, 16'hF0F0, bfp_pkg::CODE_ENQ, bfp_pkg::CODE_STX,
                   bfp_pkg::CODE_SOH, 8'h11, 8'd2, 16'h1111, bfp_pkg::CODE_ETX);
        send_frame(16'h00FF, 16'hFF00, bfp_pkg::CODE_RS, bfp_pkg::CODE_ETX,
                   bfp_pkg::CODE_ACK, 8'h22, 8'd3, 16'h2222, bfp_pkg::CODE_ETX);
        send_frame(16'h8001, 16'h7FFE, bfp_pkg::CODE_RS, bfp_pkg::CODE_STX,
                   8'h00, 8'h33, 8'd4, 16'h3333, bfp_pkg::CODE_ETX);
        send_frame(16'h0001, 16'h8000, bfp_pkg::CODE_RS, bfp_pkg::CODE_STX,
                   8'hFF, 8'h44, 8'd5, 16'h4444, bfp_pkg::CODE_ETX);
        send_frame(16'hC3C3, 16'h3C3C, bfp_pkg::CODE_RS, bfp_pkg::CODE_STX,
                   bfp_pkg::CODE_SOH, 8'h55, 8'd1, 16'h0000, bfp_pkg::CODE_ENQ);
        send_frame(16'h6996, 16'h9669, bfp_pkg::CODE_RS, bfp_pkg::CODE_STX,
                   bfp_pkg::CODE_NAK, 8'h66, 8'd0, 16'h0000, 8'hFF);
        write_limit(8'd255);
        send_frame(16'h1357, 16'h2468, bfp_pkg::CODE_RS, bfp_pkg::CODE_STX,
                   bfp_pkg::CODE_SOH, 8'h77, 8'd254, 16'hBEEF, bfp_pkg::CODE_ETX);
        send_frame(16'h2468, 16'h1357, bfp_pkg::CODE_RS, bfp_pkg::CODE_STX,
                   bfp_pkg::CODE_ACK, 8'h88, 8'd255, 16'h0000, bfp_pkg::CODE_ETX);
        write_limit(8'd0);
        send_frame(16'h0102, 16'h0304, bfp_pkg::CODE_RS, bfp_pkg::CODE_STX,
                   bfp_pkg::CODE_SOH, 8'h99, 8'd0, 16'h0000, bfp_pkg::CODE_ETX);
        send_frame(16'h0506, 16'h0708, bfp_pkg::CODE_RS, bfp_pkg::CODE_STX,
                   bfp_pkg::CODE_NAK, 8'hAA, 8'd0, 16'h0000, bfp_pkg::CODE_ETX);
        write_limit(8'd1);
        send_frame(16'h090A, 16'h0B0C, bfp_pkg::CODE_RS, bfp_pkg::CODE_STX,
                   bfp_pkg::CODE_ACK, 8'hBB, 8'd0, 16'h0000, bfp_pkg::CODE_ETX);
        send_frame(16'h0D0E, 16'h0F10, bfp_pkg::CODE_RS, bfp_pkg::CODE_STX,
                   bfp_pkg::CODE_SOH, 8'hCC, 8'd1, 16'h0000, bfp_pkg::CODE_ETX);

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: write_limit(8'd255);
                1: write_limit(8'($urandom_range(2, 254)));
                2: write_limit(8'd1);
                3: write_limit(bfp_pkg::MAX_PAYLOAD_RESET);
                default: write_limit(8'($urandom_range(1, 255)));
            endcase
            if (p == 1)
            begin
                // Stall the result side long enough to back up the input.
                random_traffic(30);
                no_idle = 1'b1;
                hold_cycles = 120;
                random_traffic(60);
                no_idle = 1'b0;
            end
            else if (p == 3)
            begin
                no_idle = 1'b1;
                random_traffic(40);
                no_idle = 1'b0;
                random_traffic(40);
            end
            else if (p == 4)
            begin
                random_traffic(40);
                settle();
                random_traffic(40);
            end
            else
            begin
                random_traffic(70);
            end
        end

        settle();
        repeat (10) @(posedge clk);
        $display("Parsed %0d bytes into %0d frame results over %0d payload limits.",
                 sb.bytes_seen, sb.results_seen, limits_used);
        $display("Status counts ok/rs/stx/dir/len/etx: %0d %0d %0d %0d %0d %0d",
                 sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
                 sb.status_hits[3], sb.status_hits[4], sb.status_hits[5]);
        if (sb.mismatches == 0 && sb.expected_frames.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout after %0t", $time);
        $display("Regression FAIL");
        $finish;
    end

endmodule
